/* hdl/sawlc_pkg.sv */
// Shared constants and types of the set-associative write-back cache.
`timescale 1ns / 1ps
package sawlc_pkg;
    localparam int ADDR_BITS  = 16;
    localparam int AGE_BITS   = 16;
    localparam int TAG_BITS   = 14;
    localparam int LINE_BITS  = 12;   // 4096 lines
    localparam int DATA_BITS  = 14;   // 16 KB of line data
    localparam int META_W     = TAG_BITS + 2 + AGE_BITS;
    localparam int META_VALID = AGE_BITS + 1;
    localparam int META_DIRTY = AGE_BITS;
    localparam int NUM_LINES  = 1 << LINE_BITS;
    localparam int DATA_DEPTH = 1 << DATA_BITS;
    localparam int MEM_DEPTH  = 1 << ADDR_BITS;

    localparam logic [1:0] REG_WAYS = 2'd0;
    localparam logic [1:0] REG_BLK  = 2'd1;
    localparam logic [1:0] REG_SIZE = 2'd2;

    // effective geometry after clamping
    typedef struct packed {
        logic [2:0] bl;   // log2 block bytes
        logic [1:0] wl;   // log2 ways
        logic [3:0] cl;   // log2 cache bytes
        logic [3:0] sb;   // set index bits
    } t_geom;
endpackage

/* hdl/sawlc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module sawlc_ram #(
    parameter int W = 8,
    parameter int D = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [0:D-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* hdl/sawlc_cfg.sv */
// Configuration registers, APB access and geometry clamping.
`timescale 1ns / 1ps
module sawlc_cfg import sawlc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_geom       o_geom,
    output logic        o_clr
);
    logic [1:0] r_ways;
    logic [2:0] r_blk;
    logic [2:0] r_size;
    logic       wr;
    logic [1:0] idx;
    logic [2:0] sk;

    assign pready = 1'b1;
    assign idx    = paddr[3:2];
    assign wr     = psel && penable && pwrite;
    assign o_clr  = wr && (idx == REG_WAYS || idx == REG_BLK || idx == REG_SIZE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ways <= 2'd0;
            r_blk  <= 3'd2;
            r_size <= 3'd0;
        end else if (wr) begin
            case (idx)
                REG_WAYS: r_ways <= pwdata[1:0];
                REG_BLK:  r_blk  <= pwdata[2:0];
                REG_SIZE: r_size <= pwdata[2:0];
                default:  ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_WAYS: prdata = {30'd0, r_ways};
            REG_BLK:  prdata = {29'd0, r_blk};
            REG_SIZE: prdata = {29'd0, r_size};
            default:  prdata = 32'd0;
        endcase
    end

    assign sk        = (r_size > 3'd4) ? 3'd4 : r_size;
    assign o_geom.bl = (r_blk < 3'd2) ? 3'd2 : r_blk;
    assign o_geom.wl = r_ways;
    assign o_geom.cl = 4'd10 + {1'b0, sk};
    assign o_geom.sb = o_geom.cl - {1'b0, o_geom.bl} - {2'b0, r_ways};
endmodule

/* hdl/set_assoc_writeback_lru_cache_core.sv */
// Top level: cache controller sequencing metadata, line data and backing memories.
//
// channel   | dir | handshake                 | payload
// s_axis    | in  | s_axis_tvalid/tready      | tdata: address, write_data; tuser: opcode
// m_axis    | out | m_axis_tvalid/tready      | tdata: read_data, hit_count, miss_count; tuser: hit
// apb       | in  | psel/penable, pready = 1  | ways_log2, block_log2, size_kb_log2
//
// For each word the ways are read one a cycle from the metadata RAM and written back one a
// cycle. A miss adds a refill, preceded by a write-back for a dirty victim, each moving
// one byte a cycle on the data RAM port.
// After reset a clearing pass zeroes backing memory and metadata; a register write
// starts a metadata clear. No word is accepted meanwhile.
// A result waiting on m_axis stalls only the end of the next word's work.
`timescale 1ns / 1ps
module set_assoc_writeback_lru_cache_core import sawlc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // address[15:0], write_data[23:16]
    input  logic        s_axis_tuser,   // opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // read_data[7:0], hit_count[39:8], miss_count[71:40]
    output logic        m_axis_tuser,   // hit
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam logic [3:0] S_IDLE = 4'd0, S_CLR = 4'd1, S_SCAN = 4'd2, S_DEC = 4'd3,
                           S_WB = 4'd4, S_FILL = 4'd5, S_ACC = 4'd6, S_RD = 4'd7,
                           S_UPD = 4'd8, S_DONE = 4'd9;

    t_geom g;
    logic  cfg_clr;

    sawlc_cfg u_cfg (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
        .prdata, .pready, .o_geom(g), .o_clr(cfg_clr)
    );

    logic [3:0]          r_state;
    logic                r_op;
    logic [15:0]         r_addr;
    logic [7:0]          r_wd;
    logic [3:0]          r_w;
    logic [2:0]          r_pw;
    logic                r_rv;
    logic                r_hit;
    logic [2:0]          r_hway;
    logic [2:0]          r_vway;
    logic [2:0]          r_way;
    logic [AGE_BITS-1:0] r_best;
    logic [META_W-1:0]   r_meta [0:7];
    logic [7:0]          r_i;
    logic [7:0]          r_rdata;
    logic [31:0]         r_hits;
    logic [31:0]         r_miss;
    logic [16:0]         r_cnt;
    logic                r_clrbk;
    logic                r_ov;
    logic [71:0]         r_otd;
    logic                r_ohit;

    // geometry of the current word
    logic [3:0]           nways;
    logic [7:0]           bsize;
    logic [15:0]          setmask;
    logic [LINE_BITS-1:0] set_v;
    logic [LINE_BITS-1:0] base;
    logic [3:0]           tsh;
    logic [TAG_BITS-1:0]  tag;
    logic [LINE_BITS-1:0] li;
    logic [DATA_BITS-1:0] dbase;
    logic [15:0]          wb;
    logic [15:0]          fb;
    logic [DATA_BITS-1:0] di;
    logic [META_W-1:0]    vmeta;
    logic [META_W-1:0]    wmeta;
    logic [15:0]          tmp_set;
    logic [15:0]          tmp_li;
    logic [TAG_BITS-1:0]  vtag;

    assign nways   = 4'd1 << g.wl;
    assign bsize   = 8'd1 << g.bl;
    assign setmask = (16'd1 << g.sb) - 16'd1;
    assign tmp_set = (r_addr >> g.bl) & setmask;
    assign set_v   = tmp_set[LINE_BITS-1:0];
    assign base    = set_v << g.wl;
    assign tsh     = g.cl - {2'b0, g.wl};
    assign tag     = TAG_BITS'(r_addr >> tsh);
    assign li      = base + {{(LINE_BITS-3){1'b0}}, r_way};
    assign tmp_li  = {4'd0, li} << g.bl;
    assign dbase   = tmp_li[DATA_BITS-1:0];
    // write-back goes to the victim's own block address
    assign vtag    = vmeta[META_W-1:AGE_BITS+2];
    assign wb      = (16'({2'b0, vtag}) << tsh) | (16'(set_v) << g.bl);
    assign fb      = r_addr & ~{8'd0, bsize - 8'd1};
    assign di      = dbase + DATA_BITS'(r_addr & {8'd0, bsize - 8'd1});
    assign vmeta   = r_meta[r_vway];
    assign wmeta   = r_meta[r_w[2:0]];

    // memories
    logic                 meta_we, data_we, back_we;
    logic [LINE_BITS-1:0] meta_wa, meta_ra;
    logic [META_W-1:0]    meta_wd, meta_rd;
    logic [DATA_BITS-1:0] data_wa, data_ra;
    logic [7:0]           data_wd, data_rd;
    logic [15:0]          back_wa, back_ra;
    logic [7:0]           back_wd, back_rd;

    sawlc_ram #(.W(META_W), .D(NUM_LINES)) u_meta (
        .i_clk, .i_we(meta_we), .i_waddr(meta_wa), .i_wdata(meta_wd),
        .i_raddr(meta_ra), .o_rdata(meta_rd)
    );
    sawlc_ram #(.W(8), .D(DATA_DEPTH)) u_data (
        .i_clk, .i_we(data_we), .i_waddr(data_wa), .i_wdata(data_wd),
        .i_raddr(data_ra), .o_rdata(data_rd)
    );
    sawlc_ram #(.W(8), .D(MEM_DEPTH)) u_back (
        .i_clk, .i_we(back_we), .i_waddr(back_wa), .i_wdata(back_wd),
        .i_raddr(back_ra), .o_rdata(back_rd)
    );

    logic [AGE_BITS-1:0] oage;
    logic                dnew;
    assign oage = wmeta[AGE_BITS-1:0];
    assign dnew = (r_hit && r_meta[r_way][META_DIRTY]) || r_op;

    always_comb begin
        meta_we = 1'b0;
        meta_wa = r_cnt[LINE_BITS-1:0];
        meta_wd = '0;
        meta_ra = base + LINE_BITS'(r_w);
        data_we = 1'b0;
        data_wa = dbase + DATA_BITS'(r_i - 8'd1);
        data_wd = back_rd;
        data_ra = dbase + DATA_BITS'(r_i);
        back_we = 1'b0;
        back_wa = r_cnt[15:0];
        back_wd = 8'd0;
        back_ra = fb + 16'(r_i);
        case (r_state)
            S_CLR: begin
                meta_we = (r_cnt < 17'(NUM_LINES));
                back_we = r_clrbk;
            end
            S_WB: begin
                back_we = (r_i != 8'd0);
                back_wa = wb + 16'(r_i - 8'd1);
                back_wd = data_rd;
            end
            S_FILL: begin
                data_we = (r_i != 8'd0);
            end
            S_ACC: begin
                data_ra = di;
                data_wa = di;
                data_wd = r_wd;
                data_we = r_op;
            end
            S_UPD: begin
                meta_we = 1'b1;
                meta_wa = base + LINE_BITS'(r_w);
                if (r_w[2:0] == r_way) begin
                    meta_wd = {tag, 1'b1, dnew, {AGE_BITS{1'b0}}};
                end else begin
                    meta_wd = {wmeta[META_W-1:AGE_BITS],
                               (&oage) ? oage : oage + 1'b1};
                end
            end
            default: ;
        endcase
    end

    logic match;
    assign match = meta_rd[META_VALID] && (meta_rd[META_W-1:AGE_BITS+2] == tag);

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_otd;
    assign m_axis_tuser  = r_ohit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_cnt   <= '0;
            r_clrbk <= 1'b1;
            r_ov    <= 1'b0;
            r_hits  <= '0;
            r_miss  <= '0;
            r_rv    <= 1'b0;
        end else begin
            if (r_ov && m_axis_tready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_op    <= s_axis_tuser;
                        r_addr  <= s_axis_tdata[15:0];
                        r_wd    <= s_axis_tdata[23:16];
                        r_w     <= '0;
                        r_rv    <= 1'b0;
                        r_hit   <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_CLR: begin
                    r_cnt <= r_cnt + 17'd1;
                    if (r_cnt == (r_clrbk ? 17'(MEM_DEPTH - 1) : 17'(NUM_LINES - 1))) begin
                        r_clrbk <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                S_SCAN: begin
                    if (r_w < nways) begin
                        r_w  <= r_w + 4'd1;
                        r_pw <= r_w[2:0];
                    end
                    r_rv <= (r_w < nways);
                    if (r_rv) begin
                        r_meta[r_pw] <= meta_rd;
                        if (match && !r_hit) begin
                            r_hit  <= 1'b1;
                            r_hway <= r_pw;
                        end
                        if (r_pw == 3'd0 || meta_rd[AGE_BITS-1:0] > r_best) begin
                            r_best <= meta_rd[AGE_BITS-1:0];
                            r_vway <= r_pw;
                        end
                        if (4'(r_pw) == nways - 4'd1) begin
                            r_state <= S_DEC;
                        end
                    end
                end
                S_DEC: begin
                    r_i <= '0;
                    if (r_hit) begin
                        r_way   <= r_hway;
                        r_hits  <= (&r_hits) ? r_hits : r_hits + 32'd1;
                        r_state <= S_ACC;
                    end else begin
                        r_way   <= r_vway;
                        r_miss  <= (&r_miss) ? r_miss : r_miss + 32'd1;
                        r_state <= (vmeta[META_VALID] && vmeta[META_DIRTY]) ? S_WB : S_FILL;
                    end
                end
                S_WB, S_FILL: begin
                    r_i <= r_i + 8'd1;
                    if (r_i == bsize) begin
                        r_i     <= '0;
                        r_state <= (r_state == S_WB) ? S_FILL : S_ACC;
                    end
                end
                S_ACC: begin
                    r_w     <= '0;
                    r_rdata <= 8'd0;
                    r_state <= r_op ? S_UPD : S_RD;
                end
                S_RD: begin
                    r_rdata <= data_rd;
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    r_w <= r_w + 4'd1;
                    if (r_w == nways - 4'd1) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_ov || m_axis_tready) begin
                        r_ov    <= 1'b1;
                        r_otd   <= {r_miss, r_hits, r_rdata};
                        r_ohit  <= r_hit;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            // register write: drop all lines and counts
            if (cfg_clr) begin
                r_state <= S_CLR;
                r_cnt   <= '0;
                r_hits  <= '0;
                r_miss  <= '0;
            end
        end
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> (r_state == S_IDLE))
        else $error("input ready outside idle");
    a_hit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEC && r_hit) |-> r_meta[r_hway][META_VALID])
        else $error("hit on an invalid way");
    a_wb_dirty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WB) |-> (vmeta[META_VALID] && vmeta[META_DIRTY] && !r_hit))
        else $error("write-back of a clean or invalid line");
    a_upd_way: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |-> (r_w < nways))
        else $error("metadata update beyond the set");
endmodule

/* tb/sv/set_assoc_writeback_lru_cache_core_test.sv */
// Testbench for the set-associative write-back LRU cache: predicts every word and checks it.
`timescale 1ns / 1ps
class cache_scoreboard;
    logic [7:0]  mem_img [0:65535];
    logic [7:0]  data_img [0:16383];
    logic [13:0] tag_img [0:4095];
    bit          valid_img [0:4095];
    bit          dirty_img [0:4095];
    logic [15:0] age_img [0:4095];
    logic [31:0] hits_q, misses_q;
    logic [1:0]  ways_r;
    logic [2:0]  blk_r, size_r;
    logic [7:0]  exp_rdata [$];
    bit          exp_hit [$];
    logic [31:0] exp_hits [$];
    logic [31:0] exp_misses [$];
    int          errors;

    function void clear_lines();
        for (int i = 0; i < 16384; i++) data_img[i] = 0;
        for (int i = 0; i < 4096; i++) begin
            tag_img[i] = 0;
            valid_img[i] = 0;
            dirty_img[i] = 0;
            age_img[i] = 0;
        end
        hits_q = 0;
        misses_q = 0;
    endfunction

    function void power_up();
        for (int i = 0; i < 65536; i++) mem_img[i] = 0;
        ways_r = 0;
        blk_r = 2;
        size_r = 0;
        clear_lines();
        errors = 0;
    endfunction

    function void set_reg(int idx, logic [31:0] val);
        if (idx == 0) ways_r = val[1:0];
        else if (idx == 1) blk_r = val[2:0];
        else size_r = val[2:0];
        clear_lines();
    endfunction

    // notes an accepted word and works out the cache access it causes
    function void note_access(bit op, logic [15:0] addr, logic [7:0] wdata);
        int bl, sk, cl, wl, sb, nways, bsize, offs, set_i, base, way, li, di, fb, wb;
        logic [31:0] tag;
        logic [15:0] best;
        bit hit;
        bl = blk_r;
        if (bl < 2) bl = 2;
        if (bl > 7) bl = 7;
        sk = size_r;
        while (sk > 0 && (1024 << sk) > 16384) sk--;
        cl = 10 + sk;
        wl = ways_r;
        while (wl > 0 && bl + wl > cl) wl--;
        sb = cl - bl - wl;
        nways = 1 << wl;
        bsize = 1 << bl;
        offs = addr & (bsize - 1);
        set_i = (addr >> bl) & ((1 << sb) - 1);
        tag = addr >> (bl + sb);
        base = set_i << wl;
        hit = 0;
        way = 0;
        for (int w = 0; w < nways; w++)
            if (!hit && valid_img[base + w] && tag_img[base + w] == tag[13:0]) begin
                hit = 1;
                way = w;
            end
        if (hit) begin
            if (hits_q != '1) hits_q++;
        end else begin
            if (misses_q != '1) misses_q++;
            best = age_img[base];
            for (int w = 1; w < nways; w++)
                if (age_img[base + w] > best) begin
                    best = age_img[base + w];
                    way = w;
                end
            li = base + way;
            if (valid_img[li] && dirty_img[li]) begin
                wb = ((tag_img[li] << (bl + sb)) | (set_i << bl)) & 16'hffff;
                for (int i = 0; i < bsize; i++)
                    mem_img[(wb + i) & 16'hffff] = data_img[((li << bl) + i) & 16'h3fff];
            end
            fb = addr & ~(bsize - 1);
            for (int i = 0; i < bsize; i++)
                data_img[((li << bl) + i) & 16'h3fff] = mem_img[(fb + i) & 16'hffff];
            valid_img[li] = 1;
            dirty_img[li] = 0;
            tag_img[li] = tag[13:0];
        end
        li = base + way;
        di = ((li << bl) + offs) & 16'h3fff;
        if (op) begin
            data_img[di] = wdata;
            dirty_img[li] = 1;
            exp_rdata.push_back(0);
        end else begin
            exp_rdata.push_back(data_img[di]);
        end
        age_img[li] = 0;
        for (int w = 0; w < nways; w++)
            if (w != way && age_img[base + w] != 16'hffff) age_img[base + w]++;
        exp_hit.push_back(hit);
        exp_hits.push_back(hits_q);
        exp_misses.push_back(misses_q);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %0h expected %0h", what, got, want);
        errors++;
    endtask

    task check_word(logic [71:0] data, bit hit);
        if (exp_hit.size() == 0) begin
            $display("MISMATCH: result word with nothing outstanding");
            errors++;
            return;
        end
        if (data[7:0] !== exp_rdata[0]) report("read_data", 32'(data[7:0]), 32'(exp_rdata[0]));
        if (hit !== exp_hit[0]) report("hit", 32'(hit), 32'(exp_hit[0]));
        if (data[39:8] !== exp_hits[0]) report("hit_count", data[39:8], exp_hits[0]);
        if (data[71:40] !== exp_misses[0]) report("miss_count", data[71:40], exp_misses[0]);
        void'(exp_rdata.pop_front());
        void'(exp_hit.pop_front());
        void'(exp_hits.pop_front());
        void'(exp_misses.pop_front());
    endtask

    function int pending();
        return exp_hit.size();
    endfunction
endclass

module set_assoc_writeback_lru_cache_core_test;
    import sawlc_pkg::*;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = 0;
    logic        s_axis_tuser = 0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [71:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [3:0]  paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic        pready;

    cache_scoreboard sb = new();
    int  cycle_cnt = 0;
    bit  sink_hold = 0;
    bit  calm = 0;
    logic [15:0] recent [$];

    set_assoc_writeback_lru_cache_core i_dut (.*);

    initial forever #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > 5000000) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // result side: random stall bursts, plus a long hold when requested
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_word(m_axis_tdata, m_axis_tuser);
    end
    initial begin
        int n;
        @(posedge i_clk);
        forever begin
            if (sink_hold) begin
                m_axis_tready <= 0;
                @(posedge i_clk);
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 3);
                m_axis_tready <= 0;
                repeat (n) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1;
                @(posedge i_clk);
            end
        end
    end

    task automatic reg_write(input int idx, input logic [31:0] val);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= 4'(idx * 4);
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        sb.set_reg(idx, val);
    endtask

    task automatic send_word(input bit op, input logic [15:0] addr, input logic [7:0] wd);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser <= op;
        s_axis_tdata <= {wd, addr};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_access(op, addr, wd);
        recent.push_back(addr);
        if (recent.size() > 16) void'(recent.pop_front());
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    // half reuse of recent addresses and neighbors so hits, evictions and write-backs occur
    function automatic logic [15:0] pick_addr();
        int r;
        r = $urandom_range(0, 9);
        if (recent.size() > 0 && r < 5)
            return recent[$urandom_range(0, recent.size() - 1)] ^ 16'($urandom_range(0, 7));
        if (r < 8)
            return {4'($urandom_range(0, 15)), 12'h0} | 16'($urandom_range(0, 255));
        return 16'($urandom_range(0, 65535));
    endfunction

    task automatic random_phase(input int count);
        for (int i = 0; i < count; i++)
            send_word(1'($urandom_range(0, 1)), pick_addr(), 8'($urandom_range(0, 255)));
    endtask

    initial begin
        int phase_cfg [8][3];
        sb.power_up();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: field extremes, read after write, eviction on a direct-mapped set
        send_word(0, 16'h0000, 8'h00);
        send_word(1, 16'hffff, 8'hff);
        send_word(1, 16'h0000, 8'ha5);
        send_word(0, 16'h0000, 8'h00);
        send_word(0, 16'hffff, 8'h00);
        send_word(1, 16'h0400, 8'h5a);     // same set, other tag: dirty eviction
        send_word(0, 16'h0000, 8'h00);     // refill from written-back memory
        send_word(0, 16'h0400, 8'h00);
        send_word(1, 16'h5555, 8'h55);
        send_word(1, 16'haaaa, 8'haa);
        send_word(0, 16'h5555, 8'h00);
        send_word(0, 16'haaaa, 8'h00);
        drain();

        // a register write discards dirty lines; memory keeps earlier write-backs
        phase_cfg = '{'{3, 2, 0}, '{1, 7, 4}, '{3, 7, 0}, '{0, 0, 7},
                      '{2, 3, 1}, '{3, 4, 4}, '{1, 5, 2}, '{2, 2, 3}};
        for (int p = 0; p < 8; p++) begin
            reg_write(0, phase_cfg[p][0]);
            reg_write(1, phase_cfg[p][1]);
            reg_write(2, phase_cfg[p][2]);
            if (p == 0) begin
                send_word(0, 16'h0400, 8'h00);
                send_word(0, 16'h5555, 8'h00);
                send_word(1, 16'h1234, 8'h01);
            end
            if (p == 2) begin
                // long receiver hold while words keep coming
                fork
                    begin
                        sink_hold = 1;
                        repeat (2000) @(posedge i_clk);
                        sink_hold = 0;
                    end
                    random_phase(20);
                join
            end
            if (p == 7) calm = 1;
            random_phase(p == 1 ? 90 : 180);
            drain();   // sender pauses until everything is back
        end

        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
